@@ hw/rtl/crcd_pkg.sv @@
// Shared types, codes and the CRC32C byte update for the frame deframer.
`timescale 1ns / 1ps

package crcd_pkg;

    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam int unsigned HDR_BYTES   = 8;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_LEN_SHORT    = 3'd1,
        ST_LEN_LONG     = 3'd2,
        ST_CRC_BAD      = 3'd3,
        ST_TYPE_UNKNOWN = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_MAX_FRAME  = 2'd0,
        CFG_TYPE_LOW   = 2'd1,
        CFG_TYPE_HIGH  = 2'd2,
        CFG_RESP_FIRST = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic        has_data;
        logic [7:0]  body_byte;
        logic        is_last;
        status_t     status;
        logic [7:0]  msg_type;
        logic        is_response;
        logic [31:0] frame_length;
    } result_t;

    // Reflected CRC32C over one byte, one bit per step.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC32C_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/crcd_stream_if.sv @@
// Valid/ready stream interface used for the byte input and the result output.
`timescale 1ns / 1ps

interface crcd_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/crc32c_frame_deframer_top.sv @@
// Each result is registered into the output register by the byte beat that causes it.
// One byte per cycle unless tx stalls a waiting result; set by the byte-wide CRC32C
// update and the header and length counters, all done within the accepting cycle.
// A new byte is taken while a result waits, as long as the output register drains.
// Reset (rst_n, asynchronous, active low) returns to the first header byte with
// the CRC at all ones and the configuration registers at their defaults.
`timescale 1ns / 1ps

module crc32c_frame_deframer_top #(
    parameter logic [31:0] MAX_FRAME_CEILING = 32'd16777216
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  crcd_pkg::cfg_index_t cfg_index,
    input  logic [31:0]          cfg_data,
    crcd_stream_if.sink          rx,
    crcd_stream_if.source        tx
);

    localparam logic [32:0] CEIL_P1 = {1'b0, MAX_FRAME_CEILING} + 33'd1;
    localparam int unsigned REM_W   = $clog2(CEIL_P1);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_TYPE   = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [2:0]         hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]        length_reg, length_next;
    logic [31:0]        exp_crc_reg, exp_crc_next;
    logic [REM_W-1:0]   remaining_reg, remaining_next;
    logic [31:0]        crc_reg, crc_next;
    logic [7:0]         type_reg, type_next;

    logic [31:0]        max_frame_reg;
    logic [7:0]         type_low_reg;
    logic [7:0]         type_high_reg;
    logic [7:0]         resp_first_reg;

    logic               out_valid_reg;
    crcd_pkg::result_t  out_data_reg;

    logic               accept;
    logic               res_valid;
    crcd_pkg::result_t  res;
    logic [7:0]         b;
    logic [31:0]        crc_upd;
    logic [7:0]         type_cur;
    logic [31:0]        limit;
    logic               type_known;

    assign rx.ready = !out_valid_reg || tx.ready;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.data.rx_byte;
    assign tx.valid = out_valid_reg;
    assign tx.data  = out_data_reg;

    assign crc_upd    = crcd_pkg::crc_byte(crc_reg, b);
    assign type_cur   = (phase_reg == PH_TYPE) ? b : type_reg;
    assign limit      = (max_frame_reg > MAX_FRAME_CEILING) ? MAX_FRAME_CEILING
                                                            : max_frame_reg;
    assign type_known = (type_cur >= type_low_reg) && (type_cur <= type_high_reg);

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        length_next    = length_reg;
        exp_crc_next   = exp_crc_reg;
        remaining_next = remaining_reg;
        crc_next       = crc_reg;
        type_next      = type_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_TYPE, PH_BODY:
                begin
                    crc_next        = crc_upd;
                    remaining_next  = remaining_reg - REM_W'(1);
                    type_next       = type_cur;
                    res.msg_type    = type_cur;
                    res.is_response = (type_cur >= resp_first_reg);
                    res.frame_length = length_reg;
                    if (remaining_reg == REM_W'(1))
                    begin
                        res_valid     = 1'b1;
                        res.has_data  = (phase_reg == PH_BODY);
                        res.body_byte = (phase_reg == PH_BODY) ? b : 8'd0;
                        res.is_last   = 1'b1;
                        if (~crc_upd != exp_crc_reg)
                        begin
                            res.status = crcd_pkg::ST_CRC_BAD;
                        end
                        else if (!type_known)
                        begin
                            res.status = crcd_pkg::ST_TYPE_UNKNOWN;
                        end
                        else
                        begin
                            res.status = crcd_pkg::ST_OK;
                        end
                        phase_next   = PH_HEADER;
                        hdr_cnt_next = '0;
                    end
                    else if (phase_reg == PH_TYPE)
                    begin
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        res_valid     = 1'b1;
                        res.has_data  = 1'b1;
                        res.body_byte = b;
                        res.status    = crcd_pkg::ST_OK;
                    end
                end
                default:
                begin
                    // Header phase; the spare phase code lands here as well.
                    phase_next = PH_HEADER;
                    if (hdr_cnt_reg == 3'd0)
                    begin
                        length_next  = {24'd0, b};
                        exp_crc_next = '0;
                    end
                    else if (!hdr_cnt_reg[2])
                    begin
                        length_next[8*hdr_cnt_reg[1:0] +: 8] = b;
                    end
                    else
                    begin
                        exp_crc_next[8*hdr_cnt_reg[1:0] +: 8] = b;
                    end

                    if (hdr_cnt_reg != 3'(crcd_pkg::HDR_BYTES - 1))
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    end
                    else
                    begin
                        hdr_cnt_next     = '0;
                        res.frame_length = length_reg;
                        res.is_last      = 1'b1;
                        if (length_reg == 32'd0)
                        begin
                            res_valid  = 1'b1;
                            res.status = crcd_pkg::ST_LEN_SHORT;
                        end
                        else if (length_reg > limit)
                        begin
                            res_valid  = 1'b1;
                            res.status = crcd_pkg::ST_LEN_LONG;
                        end
                        else
                        begin
                            remaining_next = length_reg[REM_W-1:0];
                            crc_next       = crcd_pkg::CRC_INIT;
                            phase_next     = PH_TYPE;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_cnt_reg   <= '0;
            length_reg    <= '0;
            exp_crc_reg   <= '0;
            remaining_reg <= '0;
            crc_reg       <= crcd_pkg::CRC_INIT;
            type_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            length_reg    <= length_next;
            exp_crc_reg   <= exp_crc_next;
            remaining_reg <= remaining_next;
            crc_reg       <= crc_next;
            type_reg      <= type_next;
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tx.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg  <= 32'd1048576;
            type_low_reg   <= 8'd1;
            type_high_reg  <= 8'd29;
            resp_first_reg <= 8'd15;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crcd_pkg::CFG_MAX_FRAME:  max_frame_reg  <= cfg_data;
                crcd_pkg::CFG_TYPE_LOW:   type_low_reg   <= cfg_data[7:0];
                crcd_pkg::CFG_TYPE_HIGH:  type_high_reg  <= cfg_data[7:0];
                crcd_pkg::CFG_RESP_FIRST: resp_first_reg <= cfg_data[7:0];
                default:                  max_frame_reg  <= max_frame_reg;
            endcase
        end
    end

endmodule
